// File: src/irm_pkg.sv
// ----------------------------------------------------------------------------
// irm_pkg
// Shared types and constants for the interrupt relay map: item structs,
// command and status codes, table geometry, controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package irm_pkg;

  // Table geometry
  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int IRQ_W   = 7;

  // Command codes
  localparam logic [2:0] CMD_REQUEST = 3'd0;
  localparam logic [2:0] CMD_RELEASE = 3'd1;
  localparam logic [2:0] CMD_REMAP   = 3'd2;
  localparam logic [2:0] CMD_EVENT   = 3'd3;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_BUSY      = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  // Input item
  typedef struct packed {
    logic [2:0] command;
    logic [7:0] source_irq;
    logic [7:0] target_irq;
    logic       use_message;
  } irm_in_t;

  // Result item
  typedef struct packed {
    logic [2:0]       status;
    logic             relay_valid;
    logic             relay_by_message;
    logic [IRQ_W-1:0] relay_target;
  } irm_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture item, restart scan
    logic step;    // examine one table entry
    logic commit;  // decide, update table, load result
  } irm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_last;  // entry under examination is the last one
  } irm_sts_t;

endpackage

`default_nettype wire

// File: src/interrupt_relay_map.sv
// ----------------------------------------------------------------------------
// interrupt_relay_map
// Interrupt relay table: request, release and remap mappings, and relay
// interrupt events to their mapped target. One result per item.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake          Payload
//  in_      input      in_valid/in_stall  irm_in_t  (command, source, target)
//  out_     output     out_valid/out_stall irm_out_t (status, relay fields)
//
//  Each item is accepted, then a linear scan examines every table entry in
//  turn, then the item commits: the table is updated and the result loaded.
//  Reset (rst_n low, synchronous) clears every entry's valid bit.
//  A result waiting in the output register does not block the next item;
//  the commit of that next item waits while out_stall holds the register.
//
`default_nettype none

module interrupt_relay_map import irm_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire irm_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output irm_out_t     out_data
);

  irm_cmd_t cmd;
  irm_sts_t sts;

  // Sequencer
  irm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Table and result
  irm_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// File: src/irm_ctrl.sv
// ----------------------------------------------------------------------------
// irm_ctrl
// Sequencer for one item: accept, scan every table entry, then commit the
// result once the output register is free. Owns the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module irm_ctrl import irm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  output irm_cmd_t      cmd,
  input  wire irm_sts_t sts
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // Output register can take a new result this cycle
  assign slot_free = !out_valid_r || !out_stall;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (slot_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: src/irm_datapath.sv
// ----------------------------------------------------------------------------
// irm_datapath
// Relay table, item register, scan counter with first-match and first-free
// trackers, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module irm_datapath import irm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire irm_in_t  in_data,
  input  wire irm_cmd_t cmd,
  output irm_sts_t      sts,
  output irm_out_t      out_data
);

  // Table: valid bits reset, payload does not
  logic [ENTRIES-1:0] valid_r;
  logic [IRQ_W-1:0]   src_tab_r [ENTRIES];
  logic [IRQ_W-1:0]   tgt_tab_r [ENTRIES];
  logic               msg_tab_r [ENTRIES];

  // Item and scan state
  irm_in_t            item_r;
  logic [IDX_W-1:0]   scan_idx_r;
  logic               match_found_r;
  logic [IDX_W-1:0]   match_idx_r;
  logic [IRQ_W-1:0]   match_tgt_r;
  logic               match_msg_r;
  logic               free_found_r;
  logic [IDX_W-1:0]   free_idx_r;
  irm_out_t           res_r;

  // Per-entry examination
  logic     hit;
  logic     is_free;
  logic     src_ok;
  logic     tgt_ok;

  // Commit decision
  irm_out_t         res_nxt;
  logic             wr_en;
  logic             wr_clear;
  logic             wr_fill;
  logic [IDX_W-1:0] wr_idx;

  assign src_ok  = !item_r.source_irq[7];
  assign tgt_ok  = !item_r.target_irq[7];
  assign hit     = valid_r[scan_idx_r] && src_ok &&
                   (src_tab_r[scan_idx_r] == item_r.source_irq[IRQ_W-1:0]);
  assign is_free = !valid_r[scan_idx_r];
  assign sts.scan_last = (scan_idx_r == IDX_W'(ENTRIES - 1));

  // Item capture and scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r    <= '0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
    end else if (cmd.load) begin
      scan_idx_r    <= '0;
      match_found_r <= 1'b0;
      free_found_r  <= 1'b0;
    end else if (cmd.step) begin
      scan_idx_r <= sts.scan_last ? '0 : scan_idx_r + 1'b1;
      if (hit && !match_found_r) begin
        match_found_r <= 1'b1;
      end
      if (is_free && !free_found_r) begin
        free_found_r <= 1'b1;
      end
    end
  end

  // Payload of the scan (no reset needed)
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.step && hit && !match_found_r) begin
      match_idx_r <= scan_idx_r;
      match_tgt_r <= tgt_tab_r[scan_idx_r];
      match_msg_r <= msg_tab_r[scan_idx_r];
    end
    if (cmd.step && is_free && !free_found_r) begin
      free_idx_r <= scan_idx_r;
    end
  end

  // Decide status and table update
  always_comb begin
    res_nxt  = '0;
    res_nxt.status = ST_INVALID;
    wr_clear = 1'b0;
    wr_fill  = 1'b0;
    wr_en    = 1'b0;
    wr_idx   = match_idx_r;
    case (item_r.command)
      CMD_REQUEST: begin
        if (!src_ok || !tgt_ok) begin
          res_nxt.status = ST_INVALID;
        end else if (match_found_r) begin
          res_nxt.status = ST_BUSY;
        end else if (!free_found_r) begin
          res_nxt.status = ST_FULL;
        end else begin
          res_nxt.status = ST_OK;
          wr_fill = 1'b1;
          wr_en   = 1'b1;
          wr_idx  = free_idx_r;
        end
      end
      CMD_RELEASE: begin
        if (match_found_r) begin
          res_nxt.status = ST_OK;
          wr_clear = 1'b1;
        end else begin
          res_nxt.status = ST_NOT_FOUND;
        end
      end
      CMD_REMAP: begin
        if (!tgt_ok) begin
          res_nxt.status = ST_INVALID;
        end else if (match_found_r) begin
          res_nxt.status = ST_OK;
          wr_en = 1'b1;
        end else begin
          res_nxt.status = ST_NOT_FOUND;
        end
      end
      CMD_EVENT: begin
        if (match_found_r) begin
          res_nxt.status           = ST_OK;
          res_nxt.relay_valid      = 1'b1;
          res_nxt.relay_by_message = match_msg_r;
          res_nxt.relay_target     = match_tgt_r;
        end else begin
          res_nxt.status = ST_NOT_FOUND;
        end
      end
      default: begin
        res_nxt.status = ST_INVALID;
      end
    endcase
  end

  // Table valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit) begin
      if (wr_fill) begin
        valid_r[wr_idx] <= 1'b1;
      end else if (wr_clear) begin
        valid_r[wr_idx] <= 1'b0;
      end
    end
  end

  // Table payload write
  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      tgt_tab_r[wr_idx] <= item_r.target_irq[IRQ_W-1:0];
      msg_tab_r[wr_idx] <= item_r.use_message;
      if (wr_fill) begin
        src_tab_r[wr_idx] <= item_r.source_irq[IRQ_W-1:0];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_r <= res_nxt;
    end
  end

  assign out_data = res_r;

endmodule

`default_nettype wire

// File: src/irm_checker.sv
// ----------------------------------------------------------------------------
// irm_port_checks
// Port-level checks for the interrupt relay map, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module irm_port_checks import irm_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire irm_out_t out_data
);

  // A held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // One item at a time: an accepted item blocks the next
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted during scan");

  // A relayed event always reports ok
  a_relay_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.relay_valid |-> out_data.status == ST_OK)
    else $error("relay with non-ok status");

  // Non-relayed results carry zero relay fields
  a_relay_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.relay_valid |->
      !out_data.relay_by_message && out_data.relay_target == '0)
    else $error("relay fields set without relay");

  // Reset empties the output
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind interrupt_relay_map irm_port_checks u_irm_port_checks (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
